### rtl/tsss_pkg.sv
// shared types, codes and defaults of the trace sample scale/square/smooth core
package tsss_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_GATE_DEF    = 5;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WEAK   = 2'd1;
    localparam logic [1:0] CFG_FACTOR = 2'd2;
    localparam logic [1:0] CFG_SHIFT  = 2'd3;

    typedef enum logic [1:0] {
        MODE_SCALE  = 2'd0,
        MODE_SQUARE = 2'd1,
        MODE_SMOOTH = 2'd2,
        MODE_PASS   = 2'd3
    } t_mode;

    localparam logic signed [15:0] FACTOR_RST = 16'sd256;

    typedef struct packed {
        t_mode              mode;
        logic               short_win;
        logic signed [15:0] factor;
        logic signed [31:0] shift;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       sum;
        logic       mul;
        logic       fin;
        logic       upd;
        logic       last;
        logic [2:0] lim;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic end_flag;
        logic out_free;
    } t_sts;

endpackage

### rtl/trace_sample_scale_square_smooth_core.sv
// top level of the trace sample scale/square/smooth core
// Processes one seismic trace sample per input word and returns results on the
// output stream. Scale, square and pass-through step through accept, multiply and
// output per sample; smoothing steps through accept, pick, sum, multiply and
// output for a sample that yields a result, accept and pick for one that yields
// none, pick, sum, multiply and output again for each extra result flushed at
// the end of a trace, and one more pick for each position skipped in that flush
// because it lies before the start of the trace. The order is set by the single
// shared multiplier, used once per result for the gain, the square or the
// division of the window sum by its count, and by the one output register. A new
// sample is taken once the previous one has handed its last result to the output
// register, so the output may stall while the next sample is already in work.
// Configuration is applied immediately and must only be written while idle.
module trace_sample_scale_square_smooth_core #(
    parameter int SAMPLE_BITS = tsss_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_GATE    = tsss_pkg::MAX_GATE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [1:0]                            i_cfg_index,
    input  logic [31:0]                           i_cfg_data,
    // sample stream in
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata,  // sample_value
    input  logic                                  i_s_axis_tuser,  // sample_valid
    input  logic                                  i_s_axis_tlast,  // trace_end
    // result stream out
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [31:0]                           o_m_axis_tdata,  // out_value
    output logic                                  o_m_axis_tuser,  // out_valid
    output logic                                  o_m_axis_tlast   // out_last
);

    tsss_pkg::t_cfg w_cfg;
    tsss_pkg::t_cmd w_cmd;
    tsss_pkg::t_sts w_sts;

    tsss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    tsss_ctrl #(
        .MAX_GATE (MAX_GATE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tsss_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_GATE    (MAX_GATE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_sample    ($signed(i_s_axis_tdata[SAMPLE_BITS-1:0])),
        .i_sample_ok (i_s_axis_tuser),
        .i_end       (i_s_axis_tlast),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_value     (o_m_axis_tdata),
        .o_value_ok  (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

endmodule

### rtl/tsss_cfg.sv
// configuration register file
module tsss_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output tsss_pkg::t_cfg    o_cfg
);

    tsss_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= tsss_pkg::MODE_PASS;
            r_cfg.short_win <= 1'b0;
            r_cfg.factor    <= tsss_pkg::FACTOR_RST;
            r_cfg.shift     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tsss_pkg::CFG_MODE:   r_cfg.mode      <= tsss_pkg::t_mode'(i_cfg_data[1:0]);
                tsss_pkg::CFG_WEAK:   r_cfg.short_win <= i_cfg_data[0];
                tsss_pkg::CFG_FACTOR: r_cfg.factor    <= i_cfg_data[15:0];
                tsss_pkg::CFG_SHIFT:  r_cfg.shift     <= i_cfg_data;
                default:              r_cfg           <= r_cfg;
            endcase
        end
    end

endmodule

### rtl/tsss_dp.sv
// datapath: sample history, window sum, shared multiplier, output register
module tsss_dp #(
    parameter int SAMPLE_BITS = tsss_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_GATE    = tsss_pkg::MAX_GATE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsss_pkg::t_cfg                i_cfg,
    input  tsss_pkg::t_cmd                i_cmd,
    output tsss_pkg::t_sts                o_sts,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_sample_ok,
    input  logic                          i_end,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_value,
    output logic                          o_value_ok,
    output logic                          o_last
);

    localparam int HIST = MAX_GATE - 1;
    localparam int SW   = SAMPLE_BITS + 3;          // window sum
    localparam int S    = SAMPLE_BITS + 4;          // reciprocal scaling
    localparam int RW   = S + 1;
    localparam int AW   = (SW > 16) ? SW : 16;
    localparam int BW   = RW + 1;
    localparam int PW   = AW + BW;
    localparam int QW   = SAMPLE_BITS + 1;
    localparam int EW   = ((PW > 32) ? PW : 32) + 2;

    localparam logic [RW-1:0] RECIP1 = RW'(64'd1 << S);
    localparam logic [RW-1:0] RECIP2 = RW'(64'd1 << (S - 1));
    localparam logic [RW-1:0] RECIP3 = RW'(((64'd1 << S) + 64'd2) / 64'd3);
    localparam logic [RW-1:0] RECIP4 = RW'(64'd1 << (S - 2));
    localparam logic [RW-1:0] RECIP5 = RW'(((64'd1 << S) + 64'd4) / 64'd5);

    localparam logic signed [EW-1:0] SAT_MAX = EW'(64'sh7fff_ffff);
    localparam logic signed [EW-1:0] SAT_MIN = EW'(-64'sh8000_0000);

    logic signed [SAMPLE_BITS-1:0] r_cur;
    logic                          r_cur_ok;
    logic                          r_end;
    logic signed [SAMPLE_BITS-1:0] r_hist_val [HIST];
    logic [HIST-1:0]               r_hist_ok;
    logic signed [SW-1:0]          r_sum;
    logic [2:0]                    r_cnt;
    logic signed [PW-1:0]          r_prod;
    logic                          r_out_vld;
    logic [31:0]                   r_out_val;
    logic                          r_out_ok;
    logic                          r_out_last;

    logic signed [SAMPLE_BITS-1:0] w_pos_val [MAX_GATE];
    logic [MAX_GATE-1:0]           w_pos_ok;
    logic signed [SW-1:0]          w_sum;
    logic [2:0]                    w_cnt;
    logic signed [SW-1:0]          w_mag;
    logic [RW-1:0]                 w_recip;
    logic signed [AW-1:0]          w_a;
    logic signed [BW-1:0]          w_b;
    logic signed [15:0]            w_factor;
    logic signed [31:0]            w_shift;
    logic signed [PW-1:0]          w_adj;
    logic signed [EW-1:0]          w_scaled;
    logic signed [EW-1:0]          w_sq_ext;
    logic [QW-1:0]                 w_q;
    logic signed [QW:0]            w_avg;
    logic [31:0]                   w_res;
    logic                          w_ok;
    logic                          w_out_free;

    assign w_factor   = i_cfg.factor;
    assign w_shift    = i_cfg.shift;
    assign w_out_free = !r_out_vld || i_m_tready;

    assign o_sts.end_flag = r_end;
    assign o_sts.out_free = w_out_free;
    assign o_m_tvalid     = r_out_vld;
    assign o_value        = r_out_val;
    assign o_value_ok     = r_out_ok;
    assign o_last         = r_out_last;

    // window positions: current sample first, then history newest first
    always_comb begin
        w_pos_val[0] = r_cur;
        w_pos_ok[0]  = r_cur_ok;
        for (int p = 1; p < MAX_GATE; p++) begin
            w_pos_val[p] = r_hist_val[p-1];
            w_pos_ok[p]  = r_hist_ok[p-1];
        end
    end

    always_comb begin
        w_sum = '0;
        w_cnt = '0;
        for (int p = 0; p < MAX_GATE; p++) begin
            if (w_pos_ok[p] && (3'(p) <= i_cmd.lim)) begin
                w_sum = w_sum + SW'(w_pos_val[p]);
                w_cnt = w_cnt + 3'd1;
            end
        end
    end

    assign w_mag = r_sum[SW-1] ? -r_sum : r_sum;

    always_comb begin
        unique case (r_cnt)
            3'd1:    w_recip = RECIP1;
            3'd2:    w_recip = RECIP2;
            3'd3:    w_recip = RECIP3;
            3'd4:    w_recip = RECIP4;
            3'd5:    w_recip = RECIP5;
            default: w_recip = '0;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (i_cfg.mode)
            tsss_pkg::MODE_SCALE: begin
                w_a = AW'(w_factor);
                w_b = BW'(r_cur);
            end
            tsss_pkg::MODE_SQUARE: begin
                w_a = AW'(r_cur);
                w_b = BW'(r_cur);
            end
            tsss_pkg::MODE_SMOOTH: begin
                w_a = AW'(w_mag);
                w_b = $signed({1'b0, w_recip});
            end
            tsss_pkg::MODE_PASS: begin
                w_a = '0;
                w_b = '0;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // divide by 256 rounding toward zero, then add the offset
    assign w_adj    = r_prod + (r_prod[PW-1] ? PW'(255) : PW'(0));
    assign w_scaled = EW'(w_adj >>> 8) + EW'(w_shift);
    assign w_sq_ext = EW'(r_prod);
    assign w_q      = r_prod[S +: QW];
    assign w_avg    = r_sum[SW-1] ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});

    always_comb begin
        w_res = '0;
        w_ok  = r_cur_ok;
        unique case (i_cfg.mode)
            tsss_pkg::MODE_SCALE: begin
                priority if (w_scaled > SAT_MAX) w_res = 32'h7fff_ffff;
                else if (w_scaled < SAT_MIN)      w_res = 32'h8000_0000;
                else                              w_res = w_scaled[31:0];
            end
            tsss_pkg::MODE_SQUARE: begin
                priority if (w_sq_ext > SAT_MAX) w_res = 32'h7fff_ffff;
                else                              w_res = w_sq_ext[31:0];
            end
            tsss_pkg::MODE_SMOOTH: begin
                w_res = 32'(w_avg);
                w_ok  = (r_cnt != 3'd0);
            end
            tsss_pkg::MODE_PASS: begin
                w_res = 32'(r_cur);
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur    <= i_sample;
            r_cur_ok <= i_sample_ok;
            r_end    <= i_end;
        end
        if (i_cmd.sum) begin
            r_sum <= w_sum;
            r_cnt <= w_cnt;
        end
        if (i_cmd.mul) begin
            r_prod <= w_a * w_b;
        end
        if (i_cmd.fin) begin
            r_out_val  <= w_ok ? w_res : 32'd0;
            r_out_ok   <= w_ok;
            r_out_last <= i_cmd.last;
        end
        if (i_cmd.upd && !r_end) begin
            r_hist_val[0] <= r_cur;
            for (int i = 1; i < HIST; i++) begin
                r_hist_val[i] <= r_hist_val[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_ok <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.upd) begin
                r_hist_ok <= r_end ? '0 : {r_hist_ok[HIST-2:0], r_cur_ok};
            end
            if (i_cmd.fin) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

### rtl/tsss_ctrl.sv
// controller: sequences accept, window sum, multiply and output per result
module tsss_ctrl #(
    parameter int MAX_GATE = tsss_pkg::MAX_GATE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsss_pkg::t_cfg    i_cfg,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  tsss_pkg::t_sts    i_sts,
    output tsss_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] HALF_MAX = 2'(MAX_GATE / 2);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PICK = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic [1:0] r_seen, n_seen;
    logic [1:0] w_half;
    logic       w_smooth;
    logic       w_acc;

    assign w_smooth   = (i_cfg.mode == tsss_pkg::MODE_SMOOTH);
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_acc      = i_s_tvalid && (r_state == ST_IDLE);

    always_comb begin
        w_half = i_cfg.short_win ? 2'd1 : 2'd2;
        if (w_half > HALF_MAX) begin
            w_half = HALF_MAX;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        o_cmd    = '0;
        o_cmd.lim = 3'(r_k) + 3'(w_half);
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    n_k        = w_half;
                    n_state    = w_smooth ? ST_PICK : ST_MUL;
                end
            end
            ST_PICK: begin
                // positions before the start of the trace are skipped
                if (r_k > r_seen) begin
                    if (i_sts.end_flag && (r_k != 2'd0)) begin
                        n_k = r_k - 2'd1;
                    end else begin
                        o_cmd.upd = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end else begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.last = i_sts.end_flag && (!w_smooth || (r_k == 2'd0));
                    if (w_smooth && i_sts.end_flag && (r_k != 2'd0)) begin
                        n_k     = r_k - 2'd1;
                        n_state = ST_PICK;
                    end else begin
                        o_cmd.upd = 1'b1;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_seen = r_seen;
        if (o_cmd.upd) begin
            priority if (i_sts.end_flag) n_seen = 2'd0;
            else if (r_seen != 2'd3)     n_seen = r_seen + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_seen  <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_seen  <= n_seen;
        end
    end

    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> i_sts.out_free)
        else $error("output word loaded while the output register is occupied");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PICK || r_state == ST_SUM) |-> (r_k <= HALF_MAX))
        else $error("window position beyond half a window");

    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_PICK || r_state == ST_MUL))
        else $error("accepted sample not processed");

    a_upd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd |=> (r_state == ST_IDLE && r_seen <= 2'd3))
        else $error("history update did not finish the sample");

    a_seen_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.upd && i_sts.end_flag) |=> (r_seen == 2'd0))
        else $error("trace end did not clear the sample count");

endmodule
